// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; clocked on i_clk; LRCA_ASSERT is quiet while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define LRCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every rising edge, reset included
`define LRCA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/lrca_pkg.sv =====
// shared types and constants of the led ring comet animator
// used by the top level, the scale unit and the checker; no dependencies
package lrca_pkg;

    localparam int LED_COUNT_DEF = 12;

    // configuration register indexes
    localparam logic [2:0] REG_INTERVAL   = 3'd0;
    localparam logic [2:0] REG_SPACING    = 3'd1;
    localparam logic [2:0] REG_RADIUS     = 3'd2;
    localparam logic [2:0] REG_BRIGHTNESS = 3'd3;
    localparam logic [2:0] REG_START_RED  = 3'd4;
    localparam logic [2:0] REG_START_GRN  = 3'd5;
    localparam logic [2:0] REG_START_BLU  = 3'd6;

    // reset values
    localparam logic [7:0]  RST_INTERVAL   = 8'd4;
    localparam logic [7:0]  RST_SPACING    = 8'd16;
    localparam logic [15:0] RST_RADIUS     = 16'd16;
    localparam logic [4:0]  RST_BRIGHTNESS = 5'd31;
    localparam logic [7:0]  RST_RED        = 8'd255;
    localparam logic [7:0]  RST_GREEN      = 8'd0;
    localparam logic [7:0]  RST_BLUE       = 8'd0;

    localparam logic [6:0] SAMPLE_FRAMES = 7'd100;
    localparam logic [7:0] SAMPLE_LEVEL  = 8'd8;

    // request to the shared multiply / divide unit
    typedef struct packed {
        logic        start;
        logic [7:0]  color;
        logic [15:0] weight;
    } t_scale_req;

endpackage

// ===== design/led_ring_comet_animator.sv =====
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_elapsed_ms, i_sample_arrived
// out       output     o_out_valid / i_out_ready  o_led_index .. o_last_pixel
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// an item that fires no frame leaves the sequencer in idle
// a ring frame runs every lit LED through the shared multiply / divide unit
// once for each of red, green and blue; dark LEDs skip the unit
// synchronous active-low reset; no clearing pass, ready right after reset
// a stalled output holds the sequencer; cfg writes are always taken
// depends on lrca_pkg and lrca_scale
module led_ring_comet_animator
    import lrca_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_elapsed_ms,
    input  logic        i_sample_arrived,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_led_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [4:0]  o_brightness,
    output logic        o_last_pixel,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int LW = $clog2(LED_COUNT);
    localparam logic [LW-1:0] LAST_LED = LW'(LED_COUNT - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SAMPLE = 3'd1;
    localparam logic [2:0] S_DIST   = 3'd2;
    localparam logic [2:0] S_NEAR   = 3'd3;
    localparam logic [2:0] S_SCALE  = 3'd4;
    localparam logic [2:0] S_PUT    = 3'd5;
    localparam logic [2:0] S_ADV    = 3'd6;

    logic [2:0]    r_state;
    logic [7:0]    r_interval;
    logic [7:0]    r_spacing;
    logic [15:0]   r_radius;
    logic [4:0]    r_bright;
    logic [15:0]   r_ms;
    logic [6:0]    r_frames;
    logic [13:0]   r_point;
    logic [7:0]    r_col_r;
    logic [7:0]    r_col_g;
    logic [7:0]    r_col_b;
    logic [LW-1:0] r_led;
    logic [13:0]   r_pos;
    logic [13:0]   r_len;
    logic [13:0]   r_cw;
    logic [13:0]   r_ccw;
    logic          r_ccw_big;
    logic [15:0]   r_weight;
    logic [1:0]    r_comp;
    logic          r_issue;
    logic [7:0]    r_pix_r;
    logic [7:0]    r_pix_g;
    logic [7:0]    r_pix_b;
    logic          r_out_valid;
    logic [5:0]    r_out_led;
    logic [7:0]    r_out_r;
    logic [7:0]    r_out_g;
    logic [7:0]    r_out_b;
    logic [4:0]    r_out_bright;
    logic          r_out_last;

    logic          w_in_xfer;
    logic          w_out_free;
    logic [16:0]   w_sum;
    logic [15:0]   w_ms_sat;
    logic          w_fire;
    logic [6:0]    w_frames;
    logic [13:0]   w_cw;
    logic [15:0]   w_ccw_wrap;
    logic [13:0]   w_dist;
    logic          w_near;
    logic [14:0]   w_pt_inc;
    logic [13:0]   w_pt_next;
    logic          w_last;
    t_scale_req    w_req;
    logic          w_done;
    logic [7:0]    w_quot;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last      = (r_led == LAST_LED);

    // timer add with saturation, sample reload ahead of the frame check
    assign w_sum    = {1'b0, r_ms} + {9'd0, i_elapsed_ms};
    assign w_ms_sat = w_sum[16] ? 16'hFFFF : w_sum[15:0];
    assign w_fire   = w_ms_sat > {8'd0, r_interval};
    assign w_frames = i_sample_arrived ? SAMPLE_FRAMES : r_frames;

    // ring distances; counter-clockwise can go negative when the point lies past the ring
    assign w_cw = (r_point >= r_pos) ? 14'(r_point - r_pos)
                                     : 14'({1'b0, r_len} - {1'b0, r_pos} + {1'b0, r_point});
    assign w_ccw_wrap = {2'b00, r_len} + {2'b00, r_pos} - {2'b00, r_point};

    assign w_dist = (r_ccw_big || (r_cw <= r_ccw)) ? r_cw : r_ccw;
    assign w_near = (r_radius != 16'd0) && ({2'b00, w_dist} <= r_radius);

    assign w_pt_inc  = {1'b0, r_point} + 15'd1;
    assign w_pt_next = (w_pt_inc >= {1'b0, r_len}) ? 14'd0 : w_pt_inc[13:0];

    always_comb begin
        w_req.start  = r_issue;
        w_req.weight = r_weight;
        case (r_comp)
            2'd0:    w_req.color = r_col_r;
            2'd1:    w_req.color = r_col_g;
            default: w_req.color = r_col_b;
        endcase
    end

    lrca_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_radius (r_radius),
        .o_done   (w_done),
        .o_quot   (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= RST_INTERVAL;
            r_spacing   <= RST_SPACING;
            r_radius    <= RST_RADIUS;
            r_bright    <= RST_BRIGHTNESS;
            r_ms        <= 16'd0;
            r_frames    <= 7'd0;
            r_point     <= 14'd0;
            r_col_r     <= RST_RED;
            r_col_g     <= RST_GREEN;
            r_col_b     <= RST_BLUE;
            r_issue     <= 1'b0;
            r_comp      <= 2'd0;
            r_led       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_issue <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_led <= '0;
                        r_pos <= 14'd0;
                        r_len <= 14'(LED_COUNT * r_spacing);
                        if (w_fire) begin
                            r_ms <= 16'd0;
                            if (w_frames != 7'd0) begin
                                r_frames <= w_frames - 7'd1;
                                r_state  <= S_SAMPLE;
                            end else begin
                                r_frames <= w_frames;
                                r_state  <= S_DIST;
                            end
                        end else begin
                            r_ms     <= w_ms_sat;
                            r_frames <= w_frames;
                        end
                    end
                end
                S_SAMPLE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_led    <= 6'(r_led);
                        r_out_r      <= SAMPLE_LEVEL;
                        r_out_g      <= SAMPLE_LEVEL;
                        r_out_b      <= SAMPLE_LEVEL;
                        r_out_bright <= r_bright;
                        r_out_last   <= w_last;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_led <= r_led + LW'(1);
                        end
                    end
                end
                S_DIST: begin
                    r_cw      <= w_cw;
                    r_ccw     <= (r_pos >= r_point) ? 14'(r_pos - r_point) : w_ccw_wrap[13:0];
                    r_ccw_big <= (r_pos < r_point) && w_ccw_wrap[15];
                    r_state   <= S_NEAR;
                end
                S_NEAR: begin
                    r_weight <= r_radius - {2'b00, w_dist};
                    if (w_near) begin
                        r_comp  <= 2'd0;
                        r_issue <= 1'b1;
                        r_state <= S_SCALE;
                    end else begin
                        r_pix_r <= 8'd0;
                        r_pix_g <= 8'd0;
                        r_pix_b <= 8'd0;
                        r_state <= S_PUT;
                    end
                end
                S_SCALE: begin
                    if (w_done) begin
                        case (r_comp)
                            2'd0:    r_pix_r <= w_quot;
                            2'd1:    r_pix_g <= w_quot;
                            default: r_pix_b <= w_quot;
                        endcase
                        if (r_comp == 2'd2) begin
                            r_state <= S_PUT;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_issue <= 1'b1;
                        end
                    end
                end
                S_PUT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_led    <= 6'(r_led);
                        r_out_r      <= r_pix_r;
                        r_out_g      <= r_pix_g;
                        r_out_b      <= r_pix_b;
                        r_out_bright <= r_bright;
                        r_out_last   <= w_last;
                        if (w_last) begin
                            r_state <= S_ADV;
                        end else begin
                            r_led   <= r_led + LW'(1);
                            r_pos   <= r_pos + {6'd0, r_spacing};
                            r_state <= S_DIST;
                        end
                    end
                end
                S_ADV: begin
                    r_point <= w_pt_next;
                    // color walks r to g to b to r on every wrap; all zero stays put
                    if (w_pt_next == 14'd0) begin
                        if ((r_col_r != 8'd0) && (r_col_b == 8'd0)) begin
                            r_col_r <= r_col_r - 8'd1;
                            r_col_g <= r_col_g + 8'd1;
                        end else if (r_col_g != 8'd0) begin
                            r_col_g <= r_col_g - 8'd1;
                            r_col_b <= r_col_b + 8'd1;
                        end else if (r_col_b != 8'd0) begin
                            r_col_b <= r_col_b - 8'd1;
                            r_col_r <= r_col_r + 8'd1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_INTERVAL:   r_interval <= i_cfg_data[7:0];
                    REG_SPACING:    r_spacing  <= i_cfg_data[7:0];
                    REG_RADIUS:     r_radius   <= i_cfg_data;
                    REG_BRIGHTNESS: r_bright   <= i_cfg_data[4:0];
                    REG_START_RED:  r_col_r    <= i_cfg_data[7:0];
                    REG_START_GRN:  r_col_g    <= i_cfg_data[7:0];
                    REG_START_BLU:  r_col_b    <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_led_index  = r_out_led;
    assign o_red        = r_out_r;
    assign o_green      = r_out_g;
    assign o_blue       = r_out_b;
    assign o_brightness = r_out_bright;
    assign o_last_pixel = r_out_last;

endmodule

// ===== design/lrca_scale.sv =====
// shared scale unit: quotient of color * weight / radius, weight <= radius
// a registered multiply, a load step, then eight restoring divide steps
// depends on lrca_pkg
module lrca_scale
    import lrca_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_scale_req  i_req,
    input  logic [15:0] i_radius,
    output logic        o_done,
    output logic [7:0]  o_quot
);

    logic [23:0] r_prod;
    logic [15:0] r_rem;
    logic [7:0]  r_quo;
    logic [3:0]  r_cnt;
    logic        r_load;
    logic        r_busy;
    logic        r_done;

    logic [16:0] w_trial;
    logic        w_ge;

    // product < 256 * radius, so the quotient fits 8 bits and the top 16 bits start below radius
    assign w_trial = {r_rem, r_quo[7]};
    assign w_ge    = w_trial >= {1'b0, i_radius};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            r_load <= 1'b0;
            if (i_req.start) begin
                r_prod <= {16'd0, i_req.color} * {8'd0, i_req.weight};
                r_load <= 1'b1;
            end
            if (r_load) begin
                r_rem  <= r_prod[23:8];
                r_quo  <= r_prod[7:0];
                r_cnt  <= 4'd8;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? 16'(w_trial - {1'b0, i_radius}) : w_trial[15:0];
                r_quo <= {r_quo[6:0], w_ge};
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== design/lrca_checker.sv =====
// port-level checker for the led ring comet animator, bound to the top level
// depends on lrca_pkg and assert_macros.svh
`include "assert_macros.svh"

module lrca_checker
    import lrca_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_elapsed_ms,
    input logic        i_sample_arrived,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_led_index,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic [4:0]  o_brightness,
    input logic        o_last_pixel,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    localparam logic [5:0] LAST_IDX = 6'(LED_COUNT - 1);

    // a stalled pixel holds
    `LRCA_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_led_index) && $stable(o_red) && $stable(o_green) && $stable(o_blue), "stalled pixel changed")

    // last flag marks exactly the top LED
    `LRCA_ASSERT(a_last_idx, o_out_valid |-> (o_last_pixel == (o_led_index == LAST_IDX)), "last flag does not match index")

    // pixels of one frame come in index order
    `LRCA_ASSERT(a_idx_step, o_out_valid && i_out_ready && !o_last_pixel |=> !o_out_valid || (o_led_index == $past(o_led_index) + 6'd1), "pixel index skipped")

    // no new item is taken while a frame is half delivered
    `LRCA_ASSERT(a_busy_frame, o_out_valid && !o_last_pixel |-> !o_in_ready, "ready in the middle of a frame")

    // an idle block with an empty output is still empty in the next cycle
    `LRCA_ASSERT(a_idle_quiet, o_in_ready && !o_out_valid |=> !o_out_valid, "pixel appeared straight from idle")

endmodule

bind led_ring_comet_animator lrca_checker #(.LED_COUNT(LED_COUNT)) u_lrca_checker (.*);
